>>> rtl/nvrs_pkg.sv
// Shared types and constants of the nearest-value request scheduler.
package nvrs_pkg;

  localparam int REQ_W      = 4;
  localparam int VAL_W      = 10;
  localparam int DIST_W     = 11;
  localparam int LAST_W     = 11;
  localparam int CFG_W      = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int REQ_SLOTS  = 16;

  // last served value after reset: minus one
  localparam logic [LAST_W-1:0] LAST_SERVED_RESET = '1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_PENDING   = 2'd2,
    ST_NO_ACTIVE = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BOARD_CAPACITY      = 2'd0,
    CFG_STARTING_REQUESTERS = 2'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_EMIT
  } state_e;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic              ins_en;
    logic              shift_en;
    logic [REQ_W-1:0]  ins_req;
    logic [VAL_W-1:0]  ins_val;
    logic [LAST_W-1:0] last_served;
  } cell_cmd_t;

  // search token handed from cell to cell
  typedef struct packed {
    logic              valid;
    logic              found;
    logic [DIST_W-1:0] gap;
    logic [REQ_W-1:0]  req;
    logic [VAL_W-1:0]  val;
  } token_t;

endpackage

>>> rtl/nvrs_cell.sv
// One board slot: holds an entry, shifts on removal and updates the search token.
module nvrs_cell #(
  parameter int POS  = 0,
  parameter int PW   = 4,
  parameter int CW   = 5
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  nvrs_pkg::cell_cmd_t         cmd_i,
  input  logic [CW-1:0]               count_i,
  input  logic [PW-1:0]               best_pos_i,
  input  logic [nvrs_pkg::REQ_W-1:0]  nbr_req_i,
  input  logic [nvrs_pkg::VAL_W-1:0]  nbr_val_i,
  output logic [nvrs_pkg::REQ_W-1:0]  req_o,
  output logic [nvrs_pkg::VAL_W-1:0]  val_o,
  input  nvrs_pkg::token_t            tok_i,
  input  logic [PW-1:0]               tok_pos_i,
  output nvrs_pkg::token_t            tok_o,
  output logic [PW-1:0]               tok_pos_o
);

  logic [nvrs_pkg::REQ_W-1:0]  req_q;
  logic [nvrs_pkg::VAL_W-1:0]  val_q;
  logic [nvrs_pkg::DIST_W:0]   diff;
  logic [nvrs_pkg::DIST_W:0]   neg;
  logic [nvrs_pkg::DIST_W-1:0] gap;
  logic                        in_use;
  logic                        take;
  logic                        tok_valid_q;
  logic                        tok_found_q;
  logic [nvrs_pkg::DIST_W-1:0] tok_gap_q;
  logic [nvrs_pkg::REQ_W-1:0]  tok_req_q;
  logic [nvrs_pkg::VAL_W-1:0]  tok_val_q;
  logic [PW-1:0]               tok_pos_q;

  assign diff   = {2'b00, val_q} - {cmd_i.last_served[nvrs_pkg::LAST_W-1], cmd_i.last_served};
  assign neg    = '0 - diff;
  assign gap    = diff[nvrs_pkg::DIST_W] ? neg[nvrs_pkg::DIST_W-1:0]
                                         : diff[nvrs_pkg::DIST_W-1:0];
  assign in_use = CW'(POS) < count_i;
  // later entries win ties
  assign take   = tok_i.valid && in_use && (!tok_i.found || gap <= tok_i.gap);

  always_ff @(posedge clk_i) begin
    if (cmd_i.ins_en && count_i == CW'(POS)) begin
      req_q <= cmd_i.ins_req;
      val_q <= cmd_i.ins_val;
    end else if (cmd_i.shift_en && PW'(POS) >= best_pos_i) begin
      req_q <= nbr_req_i;
      val_q <= nbr_val_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_valid_q <= 1'b0;
    end else begin
      tok_valid_q <= tok_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      tok_found_q <= 1'b1;
      tok_gap_q   <= gap;
      tok_req_q   <= req_q;
      tok_val_q   <= val_q;
      tok_pos_q   <= PW'(POS);
    end else begin
      tok_found_q <= tok_i.found;
      tok_gap_q   <= tok_i.gap;
      tok_req_q   <= tok_i.req;
      tok_val_q   <= tok_i.val;
      tok_pos_q   <= tok_pos_i;
    end
  end

  assign req_o       = req_q;
  assign val_o       = val_q;
  assign tok_o.valid = tok_valid_q;
  assign tok_o.found = tok_found_q;
  assign tok_o.gap   = tok_gap_q;
  assign tok_o.req   = tok_req_q;
  assign tok_o.val   = tok_val_q;
  assign tok_pos_o   = tok_pos_q;

endmodule

>>> rtl/nearest_value_request_scheduler_core.sv
// Top level of the nearest-value request scheduler: controller and row of board cells.
//
// Requesters post (requester, value) entries onto a board kept in arrival order, one
// outstanding entry per requester, or retire. Each input transaction yields exactly one
// result transaction carrying a status and, when the board is full and requesters remain,
// the served entry: the one whose value is nearest the last served value (ties to the
// latest arrival; last served starts at -1). The board is a row of BOARD_DEPTH cells; a
// search token walks the row one cell per cycle. An item that serves passes through the
// check, scan and emit states to the output register, and one that does not skips the
// scan, and emit waits until the output register is free. One item is in flight at a time;
// a finished result sits in the output register while the next item is accepted.
// Configuration writes are always ready and must only be issued while the block is idle.
module nearest_value_request_scheduler_core #(
  parameter int BOARD_DEPTH     = 16,
  parameter int REQUESTER_COUNT = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [nvrs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [nvrs_pkg::CFG_W-1:0]      cfg_data_i,
  // input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [15:0]                     s_axis_tdata,  // [3:0] requester, [13:4] value
  input  logic [0:0]                      s_axis_tuser,  // [0] kind
  // result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [15:0]                     m_axis_tdata,  // [1:0] status, [5:2] served_requester,
                                                         // [15:6] served_value
  output logic [0:0]                      m_axis_tuser   // [0] serve_valid
);

  localparam int PW    = (BOARD_DEPTH > 1) ? $clog2(BOARD_DEPTH) : 1;
  localparam int CW    = $clog2(BOARD_DEPTH + 1);
  localparam int CMPW  = (CW > nvrs_pkg::CFG_W) ? CW : nvrs_pkg::CFG_W;
  localparam int PN    = (REQUESTER_COUNT < nvrs_pkg::REQ_SLOTS) ? REQUESTER_COUNT
                                                                 : nvrs_pkg::REQ_SLOTS;

  // architectural state
  nvrs_pkg::state_e                 state_q, state_d;
  logic [CW-1:0]                    count_q;
  logic [nvrs_pkg::LAST_W-1:0]      last_q;
  logic [PN-1:0]                    pend_q;
  logic [nvrs_pkg::CFG_W-1:0]       retired_q;
  logic [nvrs_pkg::CFG_W-1:0]       cap_q;
  logic [nvrs_pkg::CFG_W-1:0]       start_q;

  // per-item hold and output registers
  nvrs_pkg::status_e                status_q;
  logic                             srv_valid_q;
  logic [nvrs_pkg::REQ_W-1:0]       srv_req_q;
  logic [nvrs_pkg::VAL_W-1:0]       srv_val_q;
  logic                             m_valid_q;
  logic [1:0]                       m_status_q;
  logic                             m_srv_q;
  logic [nvrs_pkg::REQ_W-1:0]       m_req_q;
  logic [nvrs_pkg::VAL_W-1:0]       m_val_q;

  // input fields
  logic                             in_kind;
  logic [nvrs_pkg::REQ_W-1:0]       in_req;
  logic [nvrs_pkg::VAL_W-1:0]       in_val;

  logic                             accept;
  logic                             req_ok;
  logic                             pend_hit;
  logic [nvrs_pkg::CFG_W-1:0]       active;
  logic                             full;
  logic                             serve_cond;
  nvrs_pkg::status_e                status_d;
  logic                             do_insert;
  logic                             do_retire;
  logic                             scan_start;
  logic                             scan_done;
  logic                             emit;
  logic                             out_free;

  // cell row
  nvrs_pkg::cell_cmd_t              cmd;
  nvrs_pkg::token_t                 tok   [BOARD_DEPTH+1];
  logic [PW-1:0]                    tpos  [BOARD_DEPTH+1];
  logic [nvrs_pkg::REQ_W-1:0]       c_req [BOARD_DEPTH+1];
  logic [nvrs_pkg::VAL_W-1:0]       c_val [BOARD_DEPTH+1];
  nvrs_pkg::token_t                 tok_end;

  assign in_kind = s_axis_tuser[0];
  assign in_req  = s_axis_tdata[3:0];
  assign in_val  = s_axis_tdata[13:4];

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == nvrs_pkg::S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign req_ok = int'(in_req) < REQUESTER_COUNT;
  always_comb begin
    pend_hit = 1'b0;
    for (int j = 0; j < PN; j++) begin
      if (in_req == nvrs_pkg::REQ_W'(j)) begin
        pend_hit = pend_q[j];
      end
    end
  end

  // active requesters floor at zero; full when count reaches the smallest limit
  assign active = (start_q > retired_q) ? start_q - retired_q : '0;
  assign full   = (CMPW'(count_q) >= CMPW'(cap_q)) ||
                  (count_q >= CW'(BOARD_DEPTH)) ||
                  (CMPW'(count_q) >= CMPW'(active));
  assign serve_cond = (count_q != '0) && (active != '0) && full;

  always_comb begin
    status_d  = nvrs_pkg::ST_OK;
    do_insert = 1'b0;
    do_retire = 1'b0;
    if (!req_ok) begin
      status_d = nvrs_pkg::ST_NO_ACTIVE;
    end else if (!in_kind) begin
      if (pend_hit) begin
        status_d = nvrs_pkg::ST_PENDING;
      end else if (full) begin
        status_d = nvrs_pkg::ST_FULL;
      end else begin
        do_insert = accept;
      end
    end else begin
      if (active == '0) begin
        status_d = nvrs_pkg::ST_NO_ACTIVE;
      end else if (pend_hit) begin
        status_d = nvrs_pkg::ST_PENDING;
      end else begin
        do_retire = accept;
      end
    end
  end

  assign tok_end  = tok[BOARD_DEPTH];
  assign out_free = !m_valid_q || m_axis_tready;

  // controller: accept, check, walk token, emit
  always_comb begin
    state_d    = state_q;
    scan_start = 1'b0;
    scan_done  = 1'b0;
    emit       = 1'b0;
    case (state_q)
      nvrs_pkg::S_IDLE: begin
        if (accept) state_d = nvrs_pkg::S_CHECK;
      end
      nvrs_pkg::S_CHECK: begin
        if (serve_cond) begin
          scan_start = 1'b1;
          state_d    = nvrs_pkg::S_SCAN;
        end else begin
          state_d = nvrs_pkg::S_EMIT;
        end
      end
      nvrs_pkg::S_SCAN: begin
        if (tok_end.valid) begin
          scan_done = 1'b1;
          state_d   = nvrs_pkg::S_EMIT;
        end
      end
      nvrs_pkg::S_EMIT: begin
        if (out_free) begin
          emit    = 1'b1;
          state_d = nvrs_pkg::S_IDLE;
        end
      end
      default: state_d = nvrs_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nvrs_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // board bookkeeping and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      last_q    <= nvrs_pkg::LAST_SERVED_RESET;
      pend_q    <= '0;
      retired_q <= '0;
      cap_q     <= nvrs_pkg::CFG_W'(16);
      start_q   <= nvrs_pkg::CFG_W'(16);
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          nvrs_pkg::CFG_BOARD_CAPACITY:      cap_q   <= cfg_data_i;
          nvrs_pkg::CFG_STARTING_REQUESTERS: start_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (do_insert) begin
        count_q <= count_q + CW'(1);
      end else if (scan_done) begin
        count_q <= count_q - CW'(1);
      end
      if (do_retire) retired_q <= retired_q + nvrs_pkg::CFG_W'(1);
      if (scan_done) last_q <= {1'b0, tok_end.val};
      for (int j = 0; j < PN; j++) begin
        if (do_insert && in_req == nvrs_pkg::REQ_W'(j)) begin
          pend_q[j] <= 1'b1;
        end else if (scan_done && tok_end.req == nvrs_pkg::REQ_W'(j)) begin
          pend_q[j] <= 1'b0;
        end
      end
    end
  end

  // per-item result hold
  always_ff @(posedge clk_i) begin
    if (accept) status_q <= status_d;
    if (state_q == nvrs_pkg::S_CHECK && !serve_cond) begin
      srv_valid_q <= 1'b0;
      srv_req_q   <= '0;
      srv_val_q   <= '0;
    end else if (scan_done) begin
      srv_valid_q <= 1'b1;
      srv_req_q   <= tok_end.req;
      srv_val_q   <= tok_end.val;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (emit) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      m_status_q <= status_q;
      m_srv_q    <= srv_valid_q;
      m_req_q    <= srv_req_q;
      m_val_q    <= srv_val_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {m_val_q, m_req_q, m_status_q};
  assign m_axis_tuser  = m_srv_q;

  // cell row: insert by count, shift down past the served slot
  assign cmd.ins_en      = do_insert;
  assign cmd.shift_en    = scan_done;
  assign cmd.ins_req     = in_req;
  assign cmd.ins_val     = in_val;
  assign cmd.last_served = last_q;

  assign tok[0].valid = scan_start;
  assign tok[0].found = 1'b0;
  assign tok[0].gap   = '0;
  assign tok[0].req   = '0;
  assign tok[0].val   = '0;
  assign tpos[0]      = '0;
  assign c_req[BOARD_DEPTH] = '0;
  assign c_val[BOARD_DEPTH] = '0;

  for (genvar i = 0; i < BOARD_DEPTH; i++) begin : g_cell
    nvrs_cell #(
      .POS (i),
      .PW  (PW),
      .CW  (CW)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd),
      .count_i    (count_q),
      .best_pos_i (tpos[BOARD_DEPTH]),
      .nbr_req_i  (c_req[i+1]),
      .nbr_val_i  (c_val[i+1]),
      .req_o      (c_req[i]),
      .val_o      (c_val[i]),
      .tok_i      (tok[i]),
      .tok_pos_i  (tpos[i]),
      .tok_o      (tok[i+1]),
      .tok_pos_o  (tpos[i+1])
    );
  end

endmodule
